// ===== design/rsb_pkg.sv =====
package rsb_pkg;

    // Fixed field widths
    localparam int DIM_W   = 7;   // sprite width and height
    localparam int SCR_W   = 13;  // screen width and height, window position
    localparam int TRIG_W  = 16;  // Q1.14 cosine and sine
    localparam int OFS_W   = 8;   // signed offset from the sprite centre
    localparam int PROD_W  = TRIG_W + OFS_W;
    localparam int IDX_W   = 12;  // sprite_index field
    localparam int PIX_W   = 32;
    localparam int SIDX_W  = 2 * DIM_W;  // row times width plus column
    localparam int REG_W   = 3;

    localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hFF00_0000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    localparam logic [REG_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
    localparam logic [REG_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
    localparam logic [REG_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [REG_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [REG_W-1:0] REG_WINDOW_LEFT   = 3'd4;
    localparam logic [REG_W-1:0] REG_WINDOW_TOP    = 3'd5;
    localparam logic [REG_W-1:0] REG_COS_Q         = 3'd6;
    localparam logic [REG_W-1:0] REG_SIN_Q         = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]  sprite_width;
        logic [DIM_W-1:0]  sprite_height;
        logic [SCR_W-1:0]  screen_width;
        logic [SCR_W-1:0]  screen_height;
        logic [SCR_W-1:0]  window_left;
        logic [SCR_W-1:0]  window_top;
        logic [TRIG_W-1:0] cos_q;
        logic [TRIG_W-1:0] sin_q;
    } cfg_t;

    // Load enables of the stages behind the input register
    typedef struct packed {
        logic b;
        logic c;
        logic d;
        logic e;
    } stage_en_t;

    // Load data carried alongside the coordinate pipeline
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] pixel;
    } item_t;

endpackage

// ===== design/rsb_xform.sv =====
module rsb_xform #(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                        aclk,
    input  rsb_pkg::stage_en_t          en,
    input  rsb_pkg::cfg_t               cfg,
    input  logic [COORD_BITS-1:0]       a_x,
    input  logic [COORD_BITS-1:0]       a_y,
    output logic                        d_ok,
    output logic [rsb_pkg::DIM_W-1:0]   d_sx,
    output logic [rsb_pkg::DIM_W-1:0]   d_sy
);

    localparam int XW = ((COORD_BITS > rsb_pkg::SCR_W) ? COORD_BITS : rsb_pkg::SCR_W) + 2;
    localparam int PW = ((TRIG_FRAC_BITS > 14) ? TRIG_FRAC_BITS : 14) + 12;
    localparam logic [PW-1:0] FRAC_MASK = PW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    logic signed [XW-1:0]  ox;
    logic signed [XW-1:0]  oy;
    logic                  in_win;
    logic signed [rsb_pkg::OFS_W-1:0] dx;
    logic signed [rsb_pkg::OFS_W-1:0] dy;

    logic                  b_in_win_reg;
    logic signed [rsb_pkg::OFS_W-1:0] b_dx_reg;
    logic signed [rsb_pkg::OFS_W-1:0] b_dy_reg;

    logic signed [rsb_pkg::PROD_W-1:0] cdx, sdy, sdx, cdy;
    logic                  c_in_win_reg;
    logic signed [rsb_pkg::PROD_W-1:0] c_cdx_reg, c_sdy_reg, c_sdx_reg, c_cdy_reg;

    logic [PW-1:0]         cx_term;
    logic [PW-1:0]         cy_term;
    logic signed [PW-1:0]  sum_x;
    logic signed [PW-1:0]  sum_y;
    logic signed [PW-1:0]  bias_x;
    logic signed [PW-1:0]  bias_y;
    logic signed [PW-1:0]  src_x;
    logic signed [PW-1:0]  src_y;
    logic                  src_ok;

    logic                  d_ok_reg;
    logic [rsb_pkg::DIM_W-1:0] d_sx_reg;
    logic [rsb_pkg::DIM_W-1:0] d_sy_reg;

    // Offset into the window, then into the sprite about its centre
    always_comb begin
        ox = $signed(XW'(a_x)) - XW'($signed(cfg.window_left));
        oy = $signed(XW'(a_y)) - XW'($signed(cfg.window_top));
        in_win = (XW'(a_x) < XW'(cfg.screen_width)) &&
                 (XW'(a_y) < XW'(cfg.screen_height)) &&
                 !ox[XW-1] && (ox < $signed(XW'(cfg.sprite_width))) &&
                 !oy[XW-1] && (oy < $signed(XW'(cfg.sprite_height)));
        // Inside the window the offsets are below 64 in magnitude.
        dx = $signed({1'b0, ox[rsb_pkg::DIM_W-1:0]}) -
             $signed({2'b00, cfg.sprite_width[rsb_pkg::DIM_W-1:1]});
        dy = $signed({1'b0, oy[rsb_pkg::DIM_W-1:0]}) -
             $signed({2'b00, cfg.sprite_height[rsb_pkg::DIM_W-1:1]});
    end

    always_ff @(posedge aclk) begin
        if (en.b) begin
            b_in_win_reg <= in_win;
            b_dx_reg     <= dx;
            b_dy_reg     <= dy;
        end
    end

    always_comb begin
        cdx = $signed(cfg.cos_q) * b_dx_reg;
        sdy = $signed(cfg.sin_q) * b_dy_reg;
        sdx = $signed(cfg.sin_q) * b_dx_reg;
        cdy = $signed(cfg.cos_q) * b_dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.c) begin
            c_in_win_reg <= b_in_win_reg;
            c_cdx_reg    <= cdx;
            c_sdy_reg    <= sdy;
            c_sdx_reg    <= sdx;
            c_cdy_reg    <= cdy;
        end
    end

    // Rotated sum plus centre, divided by the fraction scale towards zero
    always_comb begin
        cx_term = PW'(cfg.sprite_width[rsb_pkg::DIM_W-1:1]) << TRIG_FRAC_BITS;
        cy_term = PW'(cfg.sprite_height[rsb_pkg::DIM_W-1:1]) << TRIG_FRAC_BITS;
        sum_x   = PW'(c_cdx_reg) - PW'(c_sdy_reg) + cx_term;
        sum_y   = PW'(c_sdx_reg) + PW'(c_cdy_reg) + cy_term;
        bias_x  = sum_x + (sum_x[PW-1] ? FRAC_MASK : '0);
        bias_y  = sum_y + (sum_y[PW-1] ? FRAC_MASK : '0);
        src_x   = bias_x >>> TRIG_FRAC_BITS;
        src_y   = bias_y >>> TRIG_FRAC_BITS;
        src_ok  = c_in_win_reg &&
                  !src_x[PW-1] && (src_x < $signed(PW'(cfg.sprite_width))) &&
                  !src_y[PW-1] && (src_y < $signed(PW'(cfg.sprite_height)));
    end

    always_ff @(posedge aclk) begin
        if (en.d) begin
            d_ok_reg <= src_ok;
            d_sx_reg <= src_x[rsb_pkg::DIM_W-1:0];
            d_sy_reg <= src_y[rsb_pkg::DIM_W-1:0];
        end
    end

    assign d_ok = d_ok_reg;
    assign d_sx = d_sx_reg;
    assign d_sy = d_sy_reg;

endmodule

// ===== design/rsb_store.sv =====
module rsb_store #(
    parameter int SPRITE_PIXELS = 4096
) (
    input  logic                         aclk,
    input  logic                         en_e,
    input  logic                         d_valid,
    input  rsb_pkg::item_t               d_item,
    input  logic                         d_ok,
    input  logic [rsb_pkg::DIM_W-1:0]    d_sx,
    input  logic [rsb_pkg::DIM_W-1:0]    d_sy,
    input  logic [rsb_pkg::DIM_W-1:0]    sprite_width,
    output logic                         e_hit,
    output logic [rsb_pkg::PIX_W-1:0]    e_rd_data
);

    localparam int ADDR_W = (SPRITE_PIXELS > 1) ? $clog2(SPRITE_PIXELS) : 1;

    logic [rsb_pkg::PIX_W-1:0]  mem [SPRITE_PIXELS];
    logic [rsb_pkg::SIDX_W-1:0] row_base;
    logic [rsb_pkg::SIDX_W-1:0] src_idx;
    logic                       src_in_store;
    logic                       load_in_store;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       e_hit_reg;
    logic [rsb_pkg::PIX_W-1:0]  e_rd_data_reg;

    always_comb begin
        row_base      = d_sy * sprite_width;
        src_idx       = row_base + rsb_pkg::SIDX_W'(d_sx);
        src_in_store  = 32'(src_idx) < 32'(SPRITE_PIXELS);
        load_in_store = 32'(d_item.index) < 32'(SPRITE_PIXELS);
        wr_en         = en_e && d_valid && (d_item.op == rsb_pkg::OP_LOAD) && load_in_store;
        wr_addr       = ADDR_W'(d_item.index);
        rd_addr       = ADDR_W'(src_idx);
    end

    // Loads write at the same stage where blends read, so program order holds.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= d_item.pixel;
        end
        if (en_e) begin
            e_rd_data_reg <= mem[rd_addr];
            e_hit_reg     <= d_ok && src_in_store;
        end
    end

    assign e_hit     = e_hit_reg;
    assign e_rd_data = e_rd_data_reg;

endmodule

// ===== design/rotated_sprite_blend.sv =====
// Channel   Direction  Word
// s_        in         operation, sprite_index, sprite_pixel, screen_x, screen_y
// m_        out        write_enable, out_x, out_y, out_pixel (one per blend word)
// cfg_      in         cfg_index, cfg_data (register write)
//
// One word is accepted per cycle while no stage is stalled; a blend result reaches
// the output register through input, offset, multiply, source-coordinate,
// store-read and output stages.
// Each stage holds its word until the next stage is free, so a stalled output
// stops only the stages behind it that are full. Load words leave no result.
// Reset restores the register defaults; the sprite store is not cleared.
module rotated_sprite_blend #(
    parameter int SPRITE_PIXELS  = 4096,
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsb_pkg::REG_W-1:0]     cfg_index,
    input  logic [rsb_pkg::TRIG_W-1:0]    cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [rsb_pkg::IDX_W-1:0]     s_sprite_index,
    input  logic [rsb_pkg::PIX_W-1:0]     s_sprite_pixel,
    input  logic [COORD_BITS-1:0]         s_screen_x,
    input  logic [COORD_BITS-1:0]         s_screen_y,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [COORD_BITS-1:0]         m_out_x,
    output logic [COORD_BITS-1:0]         m_out_y,
    output logic [rsb_pkg::PIX_W-1:0]     m_out_pixel
);

    rsb_pkg::cfg_t      cfg_reg;
    rsb_pkg::stage_en_t en;

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic m_valid_reg;

    rsb_pkg::item_t        a_item_reg, b_item_reg, c_item_reg, d_item_reg;
    logic [COORD_BITS-1:0] a_x_reg, b_x_reg, c_x_reg, d_x_reg, e_x_reg;
    logic [COORD_BITS-1:0] a_y_reg, b_y_reg, c_y_reg, d_y_reg, e_y_reg;
    logic                  e_op_reg;

    logic                          d_ok;
    logic [rsb_pkg::DIM_W-1:0]     d_sx;
    logic [rsb_pkg::DIM_W-1:0]     d_sy;
    logic                          e_hit;
    logic [rsb_pkg::PIX_W-1:0]     e_rd_data;
    logic                          write_next;

    logic                          m_write_enable_reg;
    logic [COORD_BITS-1:0]         m_out_x_reg;
    logic [COORD_BITS-1:0]         m_out_y_reg;
    logic [rsb_pkg::PIX_W-1:0]     m_out_pixel_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sprite_width  <= 7'd64;
            cfg_reg.sprite_height <= 7'd64;
            cfg_reg.screen_width  <= 13'd4096;
            cfg_reg.screen_height <= 13'd4096;
            cfg_reg.window_left   <= '0;
            cfg_reg.window_top    <= '0;
            cfg_reg.cos_q         <= 16'd16384;
            cfg_reg.sin_q         <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rsb_pkg::REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data[6:0];
                rsb_pkg::REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data[6:0];
                rsb_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[12:0];
                rsb_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[12:0];
                rsb_pkg::REG_WINDOW_LEFT:   cfg_reg.window_left   <= cfg_data[12:0];
                rsb_pkg::REG_WINDOW_TOP:    cfg_reg.window_top    <= cfg_data[12:0];
                rsb_pkg::REG_COS_Q:         cfg_reg.cos_q         <= cfg_data;
                rsb_pkg::REG_SIN_Q:         cfg_reg.sin_q         <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        rdy_f   = !m_valid_reg || m_ready;
        rdy_e   = !e_valid_reg || rdy_f;
        rdy_d   = !d_valid_reg || rdy_e;
        rdy_c   = !c_valid_reg || rdy_d;
        rdy_b   = !b_valid_reg || rdy_c;
        rdy_a   = !a_valid_reg || rdy_b;
        s_ready = rdy_a && aresetn;
        en.b    = rdy_b;
        en.c    = rdy_c;
        en.d    = rdy_d;
        en.e    = rdy_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                a_valid_reg <= s_valid;
            end
            if (rdy_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (rdy_c) begin
                c_valid_reg <= b_valid_reg;
            end
            if (rdy_d) begin
                d_valid_reg <= c_valid_reg;
            end
            if (rdy_e) begin
                e_valid_reg <= d_valid_reg;
            end
            if (rdy_f) begin
                m_valid_reg <= e_valid_reg && (e_op_reg == rsb_pkg::OP_BLEND);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_item_reg.op    <= s_operation;
            a_item_reg.index <= s_sprite_index;
            a_item_reg.pixel <= s_sprite_pixel;
            a_x_reg          <= s_screen_x;
            a_y_reg          <= s_screen_y;
        end
        if (rdy_b) begin
            b_item_reg <= a_item_reg;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
        end
        if (rdy_c) begin
            c_item_reg <= b_item_reg;
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
        end
        if (rdy_d) begin
            d_item_reg <= c_item_reg;
            d_x_reg    <= c_x_reg;
            d_y_reg    <= c_y_reg;
        end
        if (rdy_e) begin
            e_op_reg <= d_item_reg.op;
            e_x_reg  <= d_x_reg;
            e_y_reg  <= d_y_reg;
        end
    end

    rsb_xform #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_xform (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_reg),
        .a_x  (a_x_reg),
        .a_y  (a_y_reg),
        .d_ok (d_ok),
        .d_sx (d_sx),
        .d_sy (d_sy)
    );

    rsb_store #(
        .SPRITE_PIXELS (SPRITE_PIXELS)
    ) u_store (
        .aclk         (aclk),
        .en_e         (en.e),
        .d_valid      (d_valid_reg),
        .d_item       (d_item_reg),
        .d_ok         (d_ok),
        .d_sx         (d_sx),
        .d_sy         (d_sy),
        .sprite_width (cfg_reg.sprite_width),
        .e_hit        (e_hit),
        .e_rd_data    (e_rd_data)
    );

    assign write_next = e_hit && ((e_rd_data & rsb_pkg::ALPHA_MASK) != '0);

    always_ff @(posedge aclk) begin
        if (rdy_f) begin
            m_write_enable_reg <= write_next;
            m_out_x_reg        <= e_x_reg;
            m_out_y_reg        <= e_y_reg;
            m_out_pixel_reg    <= write_next ? e_rd_data : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = m_write_enable_reg;
    assign m_out_x        = m_out_x_reg;
    assign m_out_y        = m_out_y_reg;
    assign m_out_pixel    = m_out_pixel_reg;

`ifndef ASSERT_OFF
    // The input stalls only when every stage holds a word and the output waits.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && b_valid_reg && c_valid_reg && d_valid_reg &&
                      e_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with an empty stage");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && (e_op_reg == rsb_pkg::OP_LOAD) && rdy_f) |=> !m_valid_reg)
        else $error("load word produced a result");

    a_write_has_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_write_enable_reg) |-> (m_out_pixel_reg[31:24] != 8'd0))
        else $error("write issued for a transparent pixel");

    a_no_write_zero_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_write_enable_reg) |-> (m_out_pixel_reg == '0))
        else $error("pixel not cleared without a write");
`endif

endmodule

// ===== tb/rotated_sprite_blend_checker.sv =====
`timescale 1ns / 1ps

module rotated_sprite_blend_checker (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [rsb_pkg::REG_W-1:0]  cfg_index,
    input  logic [rsb_pkg::TRIG_W-1:0] cfg_data,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_operation,
    input  logic [rsb_pkg::IDX_W-1:0]  s_sprite_index,
    input  logic [rsb_pkg::PIX_W-1:0]  s_sprite_pixel,
    input  logic [11:0]                s_screen_x,
    input  logic [11:0]                s_screen_y,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_write_enable,
    input  logic [11:0]                m_out_x,
    input  logic [11:0]                m_out_y,
    input  logic [rsb_pkg::PIX_W-1:0]  m_out_pixel,

    output int                         pending,
    output int                         failures
);

    localparam int     STORE_DEPTH = 4096;
    localparam longint TRIG_ONE    = 64'sd16384;
    localparam int     REPORT_MAX  = 10;

    typedef struct packed {
        logic                      we;
        logic [11:0]               x;
        logic [11:0]               y;
        logic [rsb_pkg::PIX_W-1:0] pixel;
    } blend_write_t;

    logic [rsb_pkg::PIX_W-1:0]         sprite_image [STORE_DEPTH];
    blend_write_t                      pending_writes [$];

    logic [rsb_pkg::DIM_W-1:0]         spr_w, spr_h;
    logic [rsb_pkg::SCR_W-1:0]         scr_w, scr_h;
    logic signed [rsb_pkg::SCR_W-1:0]  win_l, win_t;
    logic signed [rsb_pkg::TRIG_W-1:0] cos_r, sin_r;

    int fail_count = 0;

    // Nearest-neighbour rotation of the destination pixel's offset about
    // the sprite centre, with division truncating toward zero.
    function automatic blend_write_t blend_pixel_for(logic [11:0] x, logic [11:0] y);
        blend_write_t r;
        longint px, py, left, top, w, h, cx, cy, dx, dy, c, s, sx, sy, addr;
        r = '{we: 1'b0, x: x, y: y, pixel: '0};
        px = x;
        py = y;
        left = win_l;
        top = win_t;
        w = spr_w;
        h = spr_h;
        c = cos_r;
        s = sin_r;
        if (px < longint'(scr_w) && py < longint'(scr_h) &&
            px >= left && px < left + w && py >= top && py < top + h) begin
            cx = w / 2;
            cy = h / 2;
            dx = px - left - cx;
            dy = py - top - cy;
            sx = (c * dx - s * dy + cx * TRIG_ONE) / TRIG_ONE;
            sy = (s * dx + c * dy + cy * TRIG_ONE) / TRIG_ONE;
            if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
                addr = sy * w + sx;
                if (addr < STORE_DEPTH &&
                    (sprite_image[addr] & rsb_pkg::ALPHA_MASK) != 0) begin
                    r.we = 1'b1;
                    r.pixel = sprite_image[addr];
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        blend_write_t exp_w;
        if (!aresetn) begin
            spr_w = 7'd64;
            spr_h = 7'd64;
            scr_w = 13'd4096;
            scr_h = 13'd4096;
            win_l = '0;
            win_t = '0;
            cos_r = 16'sd16384;
            sin_r = '0;
            pending_writes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rsb_pkg::REG_SPRITE_WIDTH:  spr_w = cfg_data[rsb_pkg::DIM_W-1:0];
                    rsb_pkg::REG_SPRITE_HEIGHT: spr_h = cfg_data[rsb_pkg::DIM_W-1:0];
                    rsb_pkg::REG_SCREEN_WIDTH:  scr_w = cfg_data[rsb_pkg::SCR_W-1:0];
                    rsb_pkg::REG_SCREEN_HEIGHT: scr_h = cfg_data[rsb_pkg::SCR_W-1:0];
                    rsb_pkg::REG_WINDOW_LEFT:   win_l = cfg_data[rsb_pkg::SCR_W-1:0];
                    rsb_pkg::REG_WINDOW_TOP:    win_t = cfg_data[rsb_pkg::SCR_W-1:0];
                    rsb_pkg::REG_COS_Q:         cos_r = cfg_data;
                    rsb_pkg::REG_SIN_Q:         sin_r = cfg_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (pending_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected result word we=%0b x=%0d y=%0d pixel=%08h",
                                 $realtime, m_write_enable, m_out_x, m_out_y, m_out_pixel);
                end else begin
                    exp_w = pending_writes.pop_front();
                    if (m_write_enable !== exp_w.we || m_out_x !== exp_w.x ||
                        m_out_y !== exp_w.y || m_out_pixel !== exp_w.pixel) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: mismatch: expected we=%0b x=%0d y=%0d pixel=%08h,",
                                      " got we=%0b x=%0d y=%0d pixel=%08h"},
                                     $realtime, exp_w.we, exp_w.x, exp_w.y, exp_w.pixel,
                                     m_write_enable, m_out_x, m_out_y, m_out_pixel);
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_operation == rsb_pkg::OP_LOAD)
                    sprite_image[s_sprite_index] = s_sprite_pixel;
                else
                    pending_writes.push_back(blend_pixel_for(s_screen_x, s_screen_y));
            end
        end
        pending  <= pending_writes.size();
        failures <= fail_count;
    end

endmodule

// ===== tb/tb_rotated_sprite_blend.sv =====
`timescale 1ns / 1ps

module tb_rotated_sprite_blend;

    localparam int STORE_DEPTH  = 4096;
    localparam int TRIG_ONE     = 16384;
    localparam int PIPE_SETTLE  = 12;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 45;
    localparam int STRESS_PHASE = 3;

    typedef struct {
        int sw, sh, scw, sch, wl, wt, cq, sq;
    } setting_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [rsb_pkg::REG_W-1:0]  cfg_index = '0;
    logic [rsb_pkg::TRIG_W-1:0] cfg_data = '0;

    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_operation = rsb_pkg::OP_LOAD;
    logic [rsb_pkg::IDX_W-1:0]  s_sprite_index = '0;
    logic [rsb_pkg::PIX_W-1:0]  s_sprite_pixel = '0;
    logic [11:0]                s_screen_x = '0;
    logic [11:0]                s_screen_y = '0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_write_enable;
    logic [11:0]                m_out_x;
    logic [11:0]                m_out_y;
    logic [rsb_pkg::PIX_W-1:0]  m_out_pixel;

    int pending;
    int failures;

    setting_t cur = '{64, 64, 4096, 4096, 0, 0, 16384, 0};
    bit       loaded [STORE_DEPTH];
    int       burst_left = 0;
    bit       steady_sender = 1'b0;
    int       hold_requests = 0;

    rotated_sprite_blend i_dut (.*);

    rotated_sprite_blend_checker i_checker (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: stall pattern changes from segment to segment, and a long
    // hold-off is taken whenever the stimulus asks for one.
    initial begin : result_sink
        int seg_left, mode, tick, holds_seen;
        seg_left = 0;
        mode = 0;
        tick = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    2: m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Store address a blend word would read under the current setting, or -1.
    function automatic int source_address(int x, int y);
        int cx, cy, dx, dy, sx, sy, addr;
        if (!(x < cur.scw && y < cur.sch && x >= cur.wl && x < cur.wl + cur.sw &&
              y >= cur.wt && y < cur.wt + cur.sh))
            return -1;
        cx = cur.sw / 2;
        cy = cur.sh / 2;
        dx = x - cur.wl - cx;
        dy = y - cur.wt - cy;
        sx = (cur.cq * dx - cur.sq * dy + cx * TRIG_ONE) / TRIG_ONE;
        sy = (cur.sq * dx + cur.cq * dy + cy * TRIG_ONE) / TRIG_ONE;
        if (sx < 0 || sx >= cur.sw || sy < 0 || sy >= cur.sh)
            return -1;
        addr = sy * cur.sw + sx;
        return (addr < STORE_DEPTH) ? addr : -1;
    endfunction

    function automatic logic [11:0] pick_coord(int origin, int span);
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 75)
            v = origin + $urandom_range(0, (span > 0) ? span - 1 : 0);
        else if (r < 85)
            v = (r % 2 == 0) ? origin - 1 : origin + span;
        else
            v = $urandom_range(0, 4095);
        if (v < 0 || v > 4095)
            v = $urandom_range(0, 4095);
        return v[11:0];
    endfunction

    function automatic logic [rsb_pkg::PIX_W-1:0] random_pixel();
        logic [rsb_pkg::PIX_W-1:0] p;
        p = $urandom();
        if ($urandom_range(0, 4) == 0)
            p[31:24] = '0;
        return p;
    endfunction

    task automatic send_word(input logic op, input logic [rsb_pkg::IDX_W-1:0] idx,
                             input logic [rsb_pkg::PIX_W-1:0] pix, input logic [11:0] x,
                             input logic [11:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_sprite_index <= idx;
        s_sprite_pixel <= pix;
        s_screen_x     <= x;
        s_screen_y     <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic load_pixel(input int idx, input logic [rsb_pkg::PIX_W-1:0] pix);
        loaded[idx] = 1'b1;
        send_word(rsb_pkg::OP_LOAD, idx[rsb_pkg::IDX_W-1:0], pix,
                  12'($urandom()), 12'($urandom()));
    endtask

    // A blend word never reads an entry that was never written: such an
    // entry is loaded first.
    task automatic blend_at(input int x, input int y);
        int addr;
        addr = source_address(x, y);
        if (addr >= 0 && !loaded[addr])
            load_pixel(addr, random_pixel());
        send_word(rsb_pkg::OP_BLEND, rsb_pkg::IDX_W'($urandom()), $urandom(),
                  x[11:0], y[11:0]);
    endtask

    task automatic random_word();
        int area;
        if ($urandom_range(0, 99) < 25) begin
            area = cur.sw * cur.sh;
            if (area > 0 && $urandom_range(0, 1) == 0)
                load_pixel($urandom_range(0, (area < STORE_DEPTH ? area : STORE_DEPTH) - 1),
                           random_pixel());
            else
                load_pixel($urandom_range(0, STORE_DEPTH - 1), random_pixel());
        end else begin
            blend_at(pick_coord(cur.wl, cur.sw), pick_coord(cur.wt, cur.sh));
        end
    endtask

    task automatic settle_pipeline();
        int waited;
        s_valid <= 1'b0;
        burst_left = 0;
        waited = 0;
        @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [rsb_pkg::REG_W-1:0] idx, input int width,
                                  input int value);
        logic [rsb_pkg::TRIG_W-1:0] data;
        data = rsb_pkg::TRIG_W'($urandom());
        for (int b = 0; b < width; b++)
            data[b] = value[b];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic setting_t setting_for(int phase);
        setting_t s;
        real ang;
        case (phase)
            1: s = '{8, 8, 4096, 4096, 100, 200, 11585, 11585};
            2: s = '{1, 1, 1, 1, 0, 0, -16384, 0};
            3: s = '{64, 64, 4096, 4096, 4032, 4032, 0, 16384};
            4: s = '{16, 12, 300, 200, -8, -5, 15137, -6270};
            5: s = '{100, 50, 8191, 8191, 3000, 10, 16384, 0};
            6: s = '{0, 0, 0, 0, -4096, -4096, -32768, 32767};
            7: s = '{127, 127, 4096, 4096, 3969, -60, 32767, -32768};
            default: begin
                s.sw  = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 127);
                s.sh  = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 127);
                s.scw = ($urandom_range(0, 9) < 7) ? 4096 : $urandom_range(0, 8191);
                s.sch = ($urandom_range(0, 9) < 7) ? 4096 : $urandom_range(0, 8191);
                s.wl  = $urandom_range(0, 4195) - 100;
                s.wt  = $urandom_range(0, 4195) - 100;
                if ($urandom_range(0, 2) != 0) begin
                    ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                    s.cq = $rtoi($cos(ang) * 16384.0);
                    s.sq = $rtoi($sin(ang) * 16384.0);
                end else begin
                    s.cq = $urandom_range(0, 65535) - 32768;
                    s.sq = $urandom_range(0, 65535) - 32768;
                end
            end
        endcase
        return s;
    endfunction

    task automatic program_setting(input setting_t s);
        write_register(rsb_pkg::REG_SPRITE_WIDTH, rsb_pkg::DIM_W, s.sw);
        write_register(rsb_pkg::REG_SPRITE_HEIGHT, rsb_pkg::DIM_W, s.sh);
        write_register(rsb_pkg::REG_SCREEN_WIDTH, rsb_pkg::SCR_W, s.scw);
        write_register(rsb_pkg::REG_SCREEN_HEIGHT, rsb_pkg::SCR_W, s.sch);
        write_register(rsb_pkg::REG_WINDOW_LEFT, rsb_pkg::SCR_W, s.wl);
        write_register(rsb_pkg::REG_WINDOW_TOP, rsb_pkg::SCR_W, s.wt);
        write_register(rsb_pkg::REG_COS_Q, rsb_pkg::TRIG_W, s.cq);
        write_register(rsb_pkg::REG_SIN_Q, rsb_pkg::TRIG_W, s.sq);
        cfg_valid <= 1'b0;
        cur = s;
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: identity rotation of a 64 by 64 sprite at the origin.
        load_pixel(0, 32'hFFFF_FFFF);
        load_pixel(4095, 32'h00FF_FFFF);
        load_pixel(63, 32'h8000_0001);
        load_pixel(2080, 32'h0100_0000);
        blend_at(0, 0);
        blend_at(63, 63);
        blend_at(63, 0);
        blend_at(32, 32);
        blend_at(64, 0);
        blend_at(0, 64);
        blend_at(4095, 4095);
        blend_at(0, 4095);
        blend_at(4095, 0);
        load_pixel(0, 32'h0000_0000);
        blend_at(0, 0);
        load_pixel(0, 32'hFF00_0000);
        blend_at(0, 0);
        repeat (PHASE_ITEMS) random_word();

        for (int phase = 1; phase < PHASES; phase++) begin
            settle_pipeline();
            program_setting(setting_for(phase));
            steady_sender = (phase == STRESS_PHASE);
            if (phase == STRESS_PHASE)
                hold_requests++;
            repeat (PHASE_ITEMS) random_word();
        end

        settle_pipeline();
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (failures == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/rsb_pkg.sv
design/rsb_xform.sv
design/rsb_store.sv
design/rotated_sprite_blend.sv
tb/rotated_sprite_blend_checker.sv
tb/tb_rotated_sprite_blend.sv
